[hdl/lbp_pkg.sv]
// ----------------------------------------------------------------------------
// lbp_pkg
// shared types, register indexes, mode codes and code mapping tables
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_W = 16;
  localparam int MODE_W = 2;
  localparam int IMG_W_W = 11;
  localparam int PIX_W = 8;
  localparam int CODE_W = 8;
  localparam int CODE_COUNT = 256;

  // first row and column that can close a full window
  localparam int FIRST_INTERIOR = 2;
  localparam int MIN_DIM = 3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // code_mode values
  localparam logic [MODE_W-1:0] MODE_RAW     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROT_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd2;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;
  localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RESET = 16'd1024;

  typedef logic [CODE_W-1:0] code_lut_t [CODE_COUNT];

  // minimum over the eight circular rotations of each code
  function automatic code_lut_t build_rot_min_lut();
    code_lut_t lut;
    logic [CODE_W-1:0] v;
    logic [CODE_W-1:0] best;
    for (int c = 0; c < CODE_COUNT; c++) begin
      v = CODE_W'(c);
      best = v;
      for (int k = 0; k < CODE_W - 1; k++) begin
        v = {v[0], v[CODE_W-1:1]};
        if (v < best) begin
          best = v;
        end
      end
      lut[c] = best;
    end
    return lut;
  endfunction

  // uniform codes numbered 1.. in ascending order, others map to 0
  function automatic code_lut_t build_uniform_lut();
    code_lut_t lut;
    logic [CODE_W-1:0] v;
    logic [CODE_W-1:0] x;
    int idx;
    idx = 0;
    for (int c = 0; c < CODE_COUNT; c++) begin
      v = CODE_W'(c);
      x = v ^ {v[0], v[CODE_W-1:1]};
      if ($countones(x) <= 2) begin
        idx = idx + 1;
        lut[c] = CODE_W'(idx);
      end else begin
        lut[c] = '0;
      end
    end
    return lut;
  endfunction

  localparam code_lut_t ROT_MIN_LUT = build_rot_min_lut();
  localparam code_lut_t UNIFORM_LUT = build_uniform_lut();

endpackage

[hdl/lbp_ram.sv]
// ----------------------------------------------------------------------------
// lbp_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lbp_3x3_code_stream.sv]
// ----------------------------------------------------------------------------
// lbp_3x3_code_stream
// 3x3 local binary pattern codes over a raster stream of 8-bit gray pixels
// path: a taken closing pixel is registered in stage 1, and its code then in the
//   result register; a stalled result can hold the pixel in stage 1
// throughput: one pixel per cycle, set by the single read port of each
//   line store; the input stalls only while stage 1 is full and the
//   result register holds a code that is being stalled
// reset: synchronous, clears counters, window, valids and the registers;
//   line stores are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module lbp_3x3_code_stream
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel requests
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [PIX_W-1:0]       pixel,
  // code results
  output logic                   code_valid,
  input  logic                   code_stall,
  output logic [CODE_W-1:0]      pattern_code,
  output logic                   frame_last,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  // compare width wide enough for both the register and the line length
  localparam int CMP_W = ((COL_W > IMG_W_W) ? COL_W : IMG_W_W) + 1;

  // configuration registers
  logic [MODE_W-1:0]  code_mode;
  logic [IMG_W_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;

  // raster position of the next pixel
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  // stage 1: pixel waiting for its line store read data
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pix;
  logic [COL_W-1:0]  s1_col;
  logic              s1_emit;
  logic              s1_last;

  // window: [0..2] leftmost column top to bottom, [3..5] middle column
  logic [PIX_W-1:0] window [6];

  logic [PIX_W-1:0] top_rd;
  logic [PIX_W-1:0] mid_rd;

  logic              accept;
  logic              advance;
  logic [CMP_W-1:0]  width_ext;
  logic [CMP_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              col_at_end;
  logic              row_at_end;
  logic [CODE_W-1:0] raw_code;
  logic [CODE_W-1:0] mapped_code;
  logic [PIX_W-1:0]  centre;

  // ---------------------------------------------------------------------
  // register port, always ready; writes are expected only while the
  // block is idle
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_mode    <= MODE_RAW;
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_MODE:    code_mode    <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;  // unused index, write is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: stage 1 moves on whenever the result register is free
  // or being taken this cycle
  // ---------------------------------------------------------------------
  assign advance     = s1_valid && !(code_valid && code_stall);
  assign pixel_stall = s1_valid && !advance;
  assign accept      = pixel_valid && !pixel_stall;

  // ---------------------------------------------------------------------
  // raster position; width clamped to 3..MAX_WIDTH, height to at least 3
  // ---------------------------------------------------------------------
  assign width_ext = CMP_W'(image_width);

  always_comb begin
    if (width_ext < CMP_W'(MIN_DIM)) begin
      last_col = CMP_W'(MIN_DIM - 1);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      last_col = CMP_W'(MAX_WIDTH - 1);
    end else begin
      last_col = width_ext - CMP_W'(1);
    end
    if (image_height < ROW_W'(MIN_DIM)) begin
      last_row = ROW_W'(MIN_DIM - 1);
    end else begin
      last_row = image_height - ROW_W'(1);
    end
  end

  // a counter left past the end by a smaller width or height wraps to 0
  assign col_at_end = CMP_W'(column_count) >= last_col;
  assign row_at_end = row_count >= last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_at_end) begin
        column_count <= '0;
        row_count    <= row_at_end ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1 register, loaded together with the line store read data
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= pixel;
      s1_col  <= column_count;
      // the pixel closes a full window only from row 2, column 2 on
      s1_emit <= (row_count >= ROW_W'(FIRST_INTERIOR)) &&
                 (column_count >= COL_W'(FIRST_INTERIOR));
      s1_last <= row_at_end && col_at_end;
    end
  end

  // ---------------------------------------------------------------------
  // line stores: read at request time at the current column, written
  // back at the same column when the pixel leaves stage 1; neighboring
  // pixels sit in different columns, so read and write never collide
  // ---------------------------------------------------------------------
  lbp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (column_count),
    .rdata (top_rd)
  );

  lbp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (column_count),
    .rdata (mid_rd)
  );

  // ---------------------------------------------------------------------
  // window shift: the right column is the line store pair plus the pixel
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        window[i] <= '0;
      end
    end else if (advance) begin
      window[0] <= window[3];
      window[1] <= window[4];
      window[2] <= window[5];
      window[3] <= top_rd;
      window[4] <= mid_rd;
      window[5] <= s1_pix;
    end
  end

  // ---------------------------------------------------------------------
  // code: one bit per neighbor at or above the center, clockwise from
  // top-left at bit 7 down to the left neighbor at bit 0
  // ---------------------------------------------------------------------
  assign centre = window[4];

  always_comb begin
    raw_code[7] = window[0] >= centre;
    raw_code[6] = window[3] >= centre;
    raw_code[5] = top_rd    >= centre;
    raw_code[4] = mid_rd    >= centre;
    raw_code[3] = s1_pix    >= centre;
    raw_code[2] = window[5] >= centre;
    raw_code[1] = window[2] >= centre;
    raw_code[0] = window[1] >= centre;
  end

  // mode three falls back to the raw code
  always_comb begin
    case (code_mode)
      MODE_ROT_MIN: mapped_code = ROT_MIN_LUT[raw_code];
      MODE_UNIFORM: mapped_code = UNIFORM_LUT[raw_code];
      default:      mapped_code = raw_code;
    endcase
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (advance) begin
      code_valid <= s1_emit;
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_emit) begin
      pattern_code <= mapped_code;
      frame_last   <= s1_last;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !pixel_stall)
    else $error("pixel stall raised with stage 1 empty");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted pixel lost before stage 1");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_pix) && $stable(s1_col)))
    else $error("stage 1 changed while blocked");

  a_emit_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_emit) |=> code_valid)
    else $error("interior pixel produced no code");

endmodule
